[design/fsg_pkg.sv]
// shared types and constants for the falling sand grid step unit
package fsg_pkg;

	localparam int CELL_W   = 3;
	localparam int FULL_BIT = 2;
	localparam int KIND_W   = 2;
	localparam int COORD_W  = 7;
	localparam int FUNC_W   = 2;
	localparam int SEED_W   = 16;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 8;

	localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_CHK,
		ST_RD_CHK,
		ST_T_HERE_D,
		ST_T_BELOW_D,
		ST_T_RIGHT_D,
		ST_T_LEFT_D,
		ST_T_CLR,
		ST_DONE
	} fsg_state_t;

endpackage

[design/fsg_ram.sv]
// generic single write port, single read port ram with registered read
module fsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/fsg_lfsr.sv]
// 16-bit fibonacci lfsr for the diagonal side choice
module fsg_lfsr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [fsg_pkg::SEED_W-1:0] seed,
	input  logic                      step,
	output logic                      rbit
);
	import fsg_pkg::*;

	logic [SEED_W-1:0] lfsr_q;
	logic              fb;

	assign fb   = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign rbit = lfsr_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= SEED_W'(1);
		end else if (load) begin
			// a zero seed would lock the register
			lfsr_q <= (seed == '0) ? SEED_W'(1) : seed;
		end else if (step) begin
			lfsr_q <= {fb, lfsr_q[SEED_W-1:1]};
		end
	end

endmodule

[design/fsg_ctrl.sv]
// request sequencer: clear pass, add, read and the in-place grid sweep
module fsg_ctrl #(
	parameter int GRID_SIZE = 128,
	parameter int AW        = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fsg_pkg::FUNC_W-1:0]  in_func,
	input  logic [fsg_pkg::COORD_W-1:0] in_x,
	input  logic [fsg_pkg::COORD_W-1:0] in_y,
	input  logic [fsg_pkg::KIND_W-1:0]  in_kind,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_occ,
	output logic [fsg_pkg::KIND_W-1:0]  out_kind,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [fsg_pkg::CELL_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [fsg_pkg::CELL_W-1:0]  mem_rdata,
	input  logic                        rbit,
	output logic                        lfsr_step
);
	import fsg_pkg::*;

	localparam int CW = $clog2(GRID_SIZE);
	localparam logic [AW-1:0] G_A        = AW'(GRID_SIZE);
	localparam logic [AW-1:0] ROW_BACK   = AW'(2 * GRID_SIZE - 1);
	localparam logic [AW-1:0] TICK_START = AW'((GRID_SIZE - 2) * GRID_SIZE);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(GRID_SIZE * GRID_SIZE - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(GRID_SIZE - 1);
	localparam logic [CW-1:0] START_ROW  = CW'(GRID_SIZE - 2);

	fsg_state_t state_q, state_d;

	logic [AW-1:0]     addr_q;
	logic [CW-1:0]     col_q, row_q;
	logic [CELL_W-1:0] here_q;
	logic [KIND_W-1:0] kind_q;
	logic              right_free_q;
	logic              res_occ_q;
	logic [KIND_W-1:0] res_kind_q;
	logic              out_valid_q;
	logic              out_occ_q;
	logic [KIND_W-1:0] out_kind_q;

	logic              on_grid;
	logic [AW-1:0]     in_addr;
	logic [AW-1:0]     below_a, right_a, left_a, nxt_addr;
	logic              last_col, last_cell;
	logic              adv;
	logic              out_load;
	logic              accept;
	logic              cell_full;

	assign on_grid   = (32'(in_x) < 32'(GRID_SIZE)) && (32'(in_y) < 32'(GRID_SIZE));
	assign in_addr   = AW'(AW'(in_y) * G_A) + AW'(in_x);
	assign below_a   = addr_q + G_A;
	assign right_a   = below_a + AW'(1);
	assign left_a    = below_a - AW'(1);
	assign last_col  = (col_q == LAST_COL);
	assign last_cell = last_col && (row_q == '0);
	// leaving the last column jumps to the start of the row above
	assign nxt_addr  = last_col ? (addr_q - ROW_BACK) : (addr_q + AW'(1));
	assign cell_full = mem_rdata[FULL_BIT];
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_occ   = out_occ_q;
	assign out_kind  = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		lfsr_step = 1'b0;
		adv       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_ADD && on_grid) begin
						mem_re    = 1'b1;
						mem_raddr = in_addr;
						state_d   = ST_ADD_CHK;
					end else if (in_func == FUNC_READ && on_grid) begin
						mem_re    = 1'b1;
						mem_raddr = in_addr;
						state_d   = ST_RD_CHK;
					end else if (in_func == FUNC_TICK) begin
						mem_re    = 1'b1;
						mem_raddr = TICK_START;
						state_d   = ST_T_HERE_D;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ADD_CHK: begin
				if (!cell_full) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, kind_q};
				end
				state_d = ST_DONE;
			end
			ST_RD_CHK: begin
				state_d = ST_DONE;
			end
			ST_T_HERE_D: begin
				if (cell_full) begin
					mem_re    = 1'b1;
					mem_raddr = below_a;
					state_d   = ST_T_BELOW_D;
				end else begin
					adv = 1'b1;
				end
			end
			ST_T_BELOW_D: begin
				if (!cell_full) begin
					mem_we    = 1'b1;
					mem_waddr = below_a;
					mem_wdata = here_q;
					state_d   = ST_T_CLR;
				end else if (!last_col) begin
					mem_re    = 1'b1;
					mem_raddr = right_a;
					state_d   = ST_T_RIGHT_D;
				end else begin
					// right edge: only the left diagonal exists
					mem_re    = 1'b1;
					mem_raddr = left_a;
					state_d   = ST_T_LEFT_D;
				end
			end
			ST_T_RIGHT_D: begin
				if (col_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = left_a;
					state_d   = ST_T_LEFT_D;
				end else if (!cell_full) begin
					mem_we    = 1'b1;
					mem_waddr = right_a;
					mem_wdata = here_q;
					state_d   = ST_T_CLR;
				end else begin
					adv = 1'b1;
				end
			end
			ST_T_LEFT_D: begin
				if (right_free_q && !cell_full) begin
					lfsr_step = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = rbit ? left_a : right_a;
					mem_wdata = here_q;
					state_d   = ST_T_CLR;
				end else if (right_free_q) begin
					mem_we    = 1'b1;
					mem_waddr = right_a;
					mem_wdata = here_q;
					state_d   = ST_T_CLR;
				end else if (!cell_full) begin
					mem_we    = 1'b1;
					mem_waddr = left_a;
					mem_wdata = here_q;
					state_d   = ST_T_CLR;
				end else begin
					adv = 1'b1;
				end
			end
			ST_T_CLR: begin
				mem_we = 1'b1;
				adv    = 1'b1;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// step to the next cell of the sweep and fetch it, or end the sweep after the last cell
		if (adv) begin
			if (last_cell) begin
				state_d = ST_DONE;
			end else begin
				mem_re    = 1'b1;
				mem_raddr = nxt_addr;
				state_d   = ST_T_HERE_D;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + AW'(1);
			end else if (accept) begin
				addr_q <= (in_func == FUNC_TICK) ? TICK_START : in_addr;
			end else if (adv && !last_cell) begin
				addr_q <= nxt_addr;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= in_kind;
			col_q      <= '0;
			row_q      <= START_ROW;
			res_occ_q  <= 1'b0;
			res_kind_q <= '0;
		end
		if (adv && !last_cell) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q - CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
		if (state_q == ST_RD_CHK && cell_full) begin
			res_occ_q  <= 1'b1;
			res_kind_q <= mem_rdata[KIND_W-1:0];
		end
		if (state_q == ST_T_HERE_D) begin
			here_q <= mem_rdata;
		end
		if (state_q == ST_T_BELOW_D) begin
			right_free_q <= 1'b0;
		end else if (state_q == ST_T_RIGHT_D) begin
			right_free_q <= !cell_full;
		end
		if (out_load) begin
			out_occ_q  <= res_occ_q;
			out_kind_q <= res_kind_q;
		end
	end

endmodule

[design/falling_sand_grid_step_unit.sv]
// falling sand grid: add, read and tick requests over a cell memory
// add or read: a check state, then the result beat; an unused code skips the check
// one request at a time: the next beat is taken the cycle after the result is loaded
// tick: each of GRID_SIZE*(GRID_SIZE-1) cells is fetched; an empty one is skipped,
// a grain reads below and then the diagonals via the single read port of the cell memory
// reset: clearing pass over all GRID_SIZE^2 cells with s_tready low, lfsr seeded with 1
module falling_sand_grid_step_unit #(
	parameter int GRID_SIZE = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [fsg_pkg::IN_W-1:0]   s_tdata,  // func, x_coord, y_coord, grain_kind_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [fsg_pkg::OUT_W-1:0]  m_tdata,  // occupied, grain_kind_out
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fsg_pkg::SEED_W-1:0] cfg_data  // random_seed
);
	import fsg_pkg::*;

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic [FUNC_W-1:0]  func;
	logic [COORD_W-1:0] x_coord, y_coord;
	logic [KIND_W-1:0]  grain_kind_in, grain_kind_out;
	logic               occupied;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [CELL_W-1:0]  mem_wdata, mem_rdata;
	logic               rbit, lfsr_step;

	assign func          = s_tdata[1:0];
	assign x_coord       = s_tdata[8:2];
	assign y_coord       = s_tdata[15:9];
	assign grain_kind_in = s_tdata[17:16];
	assign m_tdata       = {5'b0, grain_kind_out, occupied};
	assign cfg_ready     = 1'b1;

	fsg_ctrl #(
		.GRID_SIZE(GRID_SIZE),
		.AW       (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (func),
		.in_x     (x_coord),
		.in_y     (y_coord),
		.in_kind  (grain_kind_in),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_occ  (occupied),
		.out_kind (grain_kind_out),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.rbit     (rbit),
		.lfsr_step(lfsr_step)
	);

	fsg_lfsr u_lfsr (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (cfg_valid),
		.seed  (cfg_data),
		.step  (lfsr_step),
		.rbit  (rbit)
	);

	fsg_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

[sim/tb_falling_sand_grid_step_unit.sv]
// testbench for the falling sand grid step unit: adds, reads and sweeps checked against a grid model
`timescale 1ns / 100ps

module tb_falling_sand_grid_step_unit;
	import fsg_pkg::*;

	localparam int GRID = 128;
	localparam int CELLS = GRID * GRID;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// a full sweep runs with no beat on any port, so the limit must exceed its longest run
	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct packed {
		bit            occupied;
		bit [KIND_W-1:0] kind;
	} cell_report_t;

	class sand_scoreboard;
		bit [CELL_W-1:0] cells [CELLS];
		bit [SEED_W-1:0] lfsr;
		cell_report_t    reports_due [$];
		int errors, adds, reads, sweeps, unused, side_picks, results;

		function new();
			lfsr = SEED_W'(1);
		endfunction

		function void load_seed(bit [SEED_W-1:0] seed);
			// zero seed would lock the lfsr
			lfsr = (seed == '0) ? SEED_W'(1) : seed;
		endfunction

		function bit next_side_bit();
			bit pick;
			bit fb;
			pick = lfsr[0];
			fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
			lfsr = {fb, lfsr[SEED_W-1:1]};
			side_picks++;
			return pick;
		endfunction

		function void move_grain(int from, int to);
			cells[to] = cells[from];
			cells[from] = '0;
		endfunction

		// in-place sweep, second-to-last row upward, left to right
		function void fall_sweep();
			int row, col, here, below;
			bit right_free, left_free;
			for (row = GRID - 2; row >= 0; row--) begin
				for (col = 0; col < GRID; col++) begin
					here = row * GRID + col;
					below = here + GRID;
					if (cells[here][FULL_BIT]) begin
						right_free = 1'b0;
						left_free = 1'b0;
						if (col != GRID - 1)
							right_free = !cells[below + 1][FULL_BIT];
						if (col != 0)
							left_free = !cells[below - 1][FULL_BIT];
						if (!cells[below][FULL_BIT]) begin
							move_grain(here, below);
						end else if (right_free && left_free) begin
							if (next_side_bit() == 1'b0)
								move_grain(here, below + 1);
							else
								move_grain(here, below - 1);
						end else if (right_free) begin
							move_grain(here, below + 1);
						end else if (left_free) begin
							move_grain(here, below - 1);
						end
					end
				end
			end
		endfunction

		function void note_request(bit [FUNC_W-1:0] func, bit [COORD_W-1:0] x,
				bit [COORD_W-1:0] y, bit [KIND_W-1:0] kind);
			cell_report_t rep;
			bit on_grid;
			int idx;
			rep = '0;
			on_grid = (x < GRID) && (y < GRID);
			idx = on_grid ? (y * GRID + x) : 0;
			case (func)
				FUNC_ADD: begin
					adds++;
					if (on_grid && !cells[idx][FULL_BIT])
						cells[idx] = {1'b1, kind};
				end
				FUNC_TICK: begin
					sweeps++;
					fall_sweep();
				end
				FUNC_READ: begin
					reads++;
					if (on_grid && cells[idx][FULL_BIT]) begin
						rep.occupied = 1'b1;
						rep.kind = cells[idx][KIND_W-1:0];
					end
				end
				default: unused++;
			endcase
			reports_due.push_back(rep);
		endfunction

		function void check_result(logic occ, logic [KIND_W-1:0] kind);
			cell_report_t want;
			results++;
			if (reports_due.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing pending, expected none, got occupied=%b kind=%0d",
					$time, occ, kind);
				return;
			end
			want = reports_due.pop_front();
			if (occ !== want.occupied) begin
				errors++;
				$display("%0t: occupied mismatch, expected %b, got %b", $time, want.occupied, occ);
			end
			if (kind !== want.kind) begin
				errors++;
				$display("%0t: grain kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
			end
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;   // func, x_coord, y_coord, grain_kind_in
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;        // occupied, grain_kind_out
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SEED_W-1:0]   cfg_data = '0;  // random_seed

	sand_scoreboard sb;
	bit calm = 1'b0;
	int seeds_loaded = 0;
	int quiet = 0;

	falling_sand_grid_step_unit #(
		.GRID_SIZE(GRID)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// check the result first: a request beat never has its own result on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[0], m_tdata[2:1]);
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata[1:0], s_tdata[8:2], s_tdata[15:9], s_tdata[17:16]);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, quiet);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side back-pressure
	initial begin : result_sink
		int run, hold;
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (!calm) begin
				hold = pick_gap();
				if (hold > 0) begin
					m_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [KIND_W-1:0] kind);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, kind, y, x, func};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_seed(input logic [SEED_W-1:0] seed);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.load_seed(seed);
		seeds_loaded++;
	endtask

	// most requests land near the floor in three narrow bands so grains pile up
	task automatic random_item(input bit sweep_now);
		logic [FUNC_W-1:0]  func;
		logic [COORD_W-1:0] x, y;
		logic [KIND_W-1:0]  kind;
		int pick;
		pick = $urandom_range(0, 99);
		kind = KIND_W'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end else begin
			case ($urandom_range(0, 2))
				0: x = COORD_W'($urandom_range(0, 3));
				1: x = COORD_W'($urandom_range(GRID - 4, GRID - 1));
				default: x = COORD_W'($urandom_range(GRID / 2 - 2, GRID / 2 + 2));
			endcase
			y = COORD_W'($urandom_range(GRID - 6, GRID - 1));
		end
		if (sweep_now)
			func = FUNC_TICK;
		else if (pick < 48)
			func = FUNC_ADD;
		else if (pick < 94)
			func = FUNC_READ;
		else
			func = FUNC_UNUSED;
		send_request(func, x, y, kind);
	endtask

	initial begin : stimulus
		int phase, i;
		logic [SEED_W-1:0] seed;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_seed('0);
		send_request(FUNC_READ, 7'd0, 7'd0, 2'd0);
		send_request(FUNC_READ, 7'd127, 7'd127, 2'd0);
		send_request(FUNC_ADD, 7'd0, 7'd127, 2'd3);
		send_request(FUNC_ADD, 7'd127, 7'd127, 2'd1);
		// occupied target must be left alone
		send_request(FUNC_ADD, 7'd127, 7'd127, 2'd2);
		send_request(FUNC_READ, 7'd127, 7'd127, 2'd0);
		send_request(FUNC_ADD, 7'd0, 7'd0, 2'd0);
		send_request(FUNC_ADD, 7'd127, 7'd0, 2'd2);
		// both diagonals free: random side
		send_request(FUNC_ADD, 7'd64, 7'd127, 2'd1);
		send_request(FUNC_ADD, 7'd64, 7'd126, 2'd2);
		// edge columns never look off the grid
		send_request(FUNC_ADD, 7'd0, 7'd126, 2'd2);
		send_request(FUNC_ADD, 7'd127, 7'd126, 2'd3);
		// right diagonal blocked
		send_request(FUNC_ADD, 7'd10, 7'd127, 2'd1);
		send_request(FUNC_ADD, 7'd11, 7'd127, 2'd0);
		send_request(FUNC_ADD, 7'd10, 7'd126, 2'd3);
		// fully blocked grain stays put
		send_request(FUNC_ADD, 7'd30, 7'd127, 2'd2);
		send_request(FUNC_ADD, 7'd29, 7'd127, 2'd1);
		send_request(FUNC_ADD, 7'd31, 7'd127, 2'd3);
		send_request(FUNC_ADD, 7'd30, 7'd126, 2'd0);
		send_request(FUNC_UNUSED, 7'd127, 7'd127, 2'd3);
		send_request(FUNC_TICK, 7'd0, 7'd0, 2'd0);
		send_request(FUNC_READ, 7'd65, 7'd127, 2'd0);
		send_request(FUNC_READ, 7'd1, 7'd127, 2'd0);
		send_request(FUNC_READ, 7'd126, 7'd127, 2'd0);
		send_request(FUNC_READ, 7'd9, 7'd127, 2'd0);
		send_request(FUNC_READ, 7'd30, 7'd126, 2'd0);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			calm = (phase == 2);
			case (phase)
				0: seed = 16'hFFFF;
				1: seed = 16'h0001;
				default: seed = SEED_W'($urandom_range(1, 65535));
			endcase
			write_seed(seed);
			for (i = 0; i < 25; i++)
				random_item(i == 8 || i == 17);
			drain();
		end

		repeat (16) @(posedge clk);
		$display("covered %0d requests: %0d adds, %0d reads, %0d sweeps, %0d unused codes",
			sb.adds + sb.reads + sb.sweeps + sb.unused, sb.adds, sb.reads, sb.sweeps, sb.unused);
		$display("%0d seeds loaded, %0d random side choices, %0d result beats checked",
			seeds_loaded, sb.side_picks, sb.results);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
design/fsg_pkg.sv
design/fsg_ram.sv
design/fsg_lfsr.sv
design/fsg_ctrl.sv
design/falling_sand_grid_step_unit.sv
sim/tb_falling_sand_grid_step_unit.sv
